FILE: rtl/bmf_pkg.sv
// bmf_pkg: shared constants, types and helpers of the binaural multichannel fir
// used by bmf_front, bmf_back and the top level; no dependencies
`timescale 1ns / 1ps

package bmf_pkg;

    localparam int MAX_TAPS      = 512;
    localparam int MAX_HARMONICS = 16;
    localparam int TAP_W         = 9;
    localparam int HARM_W        = 4;
    localparam int DEPTH         = MAX_TAPS * MAX_HARMONICS;
    localparam int ADDR_W        = TAP_W + HARM_W;
    localparam int SAMPLE_W      = 16;
    localparam int ACC_W         = 40;
    localparam int TAPS_CFG_W    = 10;
    localparam int HARM_CFG_W    = 5;
    localparam int CFG_W         = 10;

    typedef enum logic
    {
        CFG_TAPS      = 1'b0,
        CFG_HARMONICS = 1'b1
    } cfg_index_t;

    typedef enum logic
    {
        KIND_SAMPLE = 1'b0,
        KIND_COEF   = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t               kind;
        logic                last;
        logic                ear;
        logic [HARM_W-1:0]   harmonic;
        logic [TAP_W-1:0]    tap;
        logic [SAMPLE_W-1:0] value;
    } item_t;

    typedef struct packed
    {
        logic  valid;
        item_t item;
    } queue_t;

    typedef struct packed
    {
        logic pop;
        logic clearing;
    } back_status_t;

    // last harmonic index in use, with out-of-range register values clamped
    function automatic logic [HARM_W-1:0] last_harmonic(input logic [HARM_CFG_W-1:0] n);
        logic [HARM_W-1:0] r;
        if (n == '0)
            r = '0;
        else if (n > HARM_CFG_W'(MAX_HARMONICS))
            r = HARM_W'(MAX_HARMONICS - 1);
        else
            r = HARM_W'(n - 1'b1);
        return r;
    endfunction

    function automatic logic [TAP_W-1:0] last_tap(input logic [TAPS_CFG_W-1:0] n);
        logic [TAP_W-1:0] r;
        if (n == '0)
            r = '0;
        else if (n > TAPS_CFG_W'(MAX_TAPS))
            r = TAP_W'(MAX_TAPS - 1);
        else
            r = TAP_W'(n - 1'b1);
        return r;
    endfunction

endpackage

FILE: rtl/bmf_ram.sv
// bmf_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module bmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/bmf_front.sv
// bmf_front: accepts input items, drops samples of unused harmonics, queues the rest
// depends on bmf_pkg
`timescale 1ns / 1ps

module bmf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [bmf_pkg::HARM_W-1:0]    harmonic,
    input  logic [bmf_pkg::TAP_W-1:0]     tap,
    input  logic                          ear,
    input  logic [bmf_pkg::HARM_CFG_W-1:0] harmonics_in_use,
    input  logic signed [bmf_pkg::SAMPLE_W-1:0] sample_in,
    input  logic signed [bmf_pkg::SAMPLE_W-1:0] coefficient,
    input  bmf_pkg::back_status_t         status,
    output bmf_pkg::queue_t               q
);
    import bmf_pkg::*;

    item_t             slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [HARM_W-1:0] h_last;
    logic              keep;
    logic              push;
    logic              pop;
    item_t             new_item;

    assign h_last   = last_harmonic(harmonics_in_use);
    assign in_stall = (count_reg == 2'd2) || status.clearing;
    assign keep     = req_type || (harmonic <= h_last);
    assign push     = in_valid && !in_stall && keep;
    assign pop      = status.pop && (count_reg != 2'd0);

    always_comb
    begin
        new_item.kind     = req_type ? KIND_COEF : KIND_SAMPLE;
        new_item.last     = (harmonic == h_last);
        new_item.ear      = ear;
        new_item.harmonic = harmonic;
        new_item.tap      = tap;
        new_item.value    = req_type ? coefficient : sample_in;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign q.valid = (count_reg != 2'd0);
    assign q.item  = slot_reg[rd_ptr_reg];

endmodule

FILE: rtl/bmf_back.sv
// bmf_back: sequencer with one mac per ear, coefficient and history rams, output register
// depends on bmf_pkg and bmf_ram
`timescale 1ns / 1ps

module bmf_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bmf_pkg::queue_t                q,
    output bmf_pkg::back_status_t          status,
    input  logic [bmf_pkg::TAPS_CFG_W-1:0] taps_in_use,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [bmf_pkg::SAMPLE_W-1:0] left_sample,
    output logic signed [bmf_pkg::SAMPLE_W-1:0] right_sample
);
    import bmf_pkg::*;

    typedef enum logic [2:0]
    {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH,
        ST_CLEAR
    } state_t;

    state_t              state_reg;
    item_t               cur_reg;
    logic [TAP_W-1:0]    pos_reg;
    logic [TAP_W-1:0]    t_reg;
    logic [HARM_W-1:0]   row_cnt_reg;
    logic [ADDR_W-1:0]   init_cnt_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] left_reg;
    logic [SAMPLE_W-1:0] right_reg;

    logic                rd_v_reg;
    logic                mul_v_reg;
    logic signed [2*SAMPLE_W-1:0] prod_l_reg;
    logic signed [2*SAMPLE_W-1:0] prod_r_reg;
    logic signed [ACC_W-1:0]      acc_l_reg;
    logic signed [ACC_W-1:0]      acc_r_reg;

    logic [TAP_W-1:0]    t_last;
    logic                issue;
    logic                acc_clear;
    logic                out_free;
    logic                hist_we;
    logic [ADDR_W-1:0]   hist_waddr;
    logic [SAMPLE_W-1:0] hist_wdata;
    logic [ADDR_W-1:0]   hist_raddr;
    logic [ADDR_W-1:0]   coef_addr_r;
    logic [ADDR_W-1:0]   coef_addr_w;
    logic                coef_we_l;
    logic                coef_we_r;
    logic signed [SAMPLE_W-1:0] hist_q;
    logic signed [SAMPLE_W-1:0] coef_l_q;
    logic signed [SAMPLE_W-1:0] coef_r_q;
    logic [SAMPLE_W-1:0] sat_l;
    logic [SAMPLE_W-1:0] sat_r;

    function automatic logic [SAMPLE_W-1:0] saturate(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-16:0] s;
        logic [SAMPLE_W-1:0]      r;
        s = a[ACC_W-1:15];
        if (s > (ACC_W-15)'(32767))
            r = 16'h7fff;
        else if (s < -(ACC_W-15)'(32768))
            r = 16'h8000;
        else
            r = s[SAMPLE_W-1:0];
        return r;
    endfunction

    assign t_last    = last_tap(taps_in_use);
    assign issue     = (state_reg == ST_MAC);
    assign out_free  = !out_valid_reg || !out_stall;
    assign acc_clear = (state_reg == ST_FINISH) && out_free;
    assign sat_l     = saturate(acc_l_reg);
    assign sat_r     = saturate(acc_r_reg);

    assign hist_raddr  = {pos_reg - t_reg, cur_reg.harmonic};
    assign coef_addr_r = {t_reg, cur_reg.harmonic};
    assign coef_addr_w = {cur_reg.tap, cur_reg.harmonic};
    assign coef_we_l   = (state_reg == ST_EXEC) && (cur_reg.kind == KIND_COEF) && !cur_reg.ear;
    assign coef_we_r   = (state_reg == ST_EXEC) && (cur_reg.kind == KIND_COEF) && cur_reg.ear;

    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = {pos_reg, cur_reg.harmonic};
        hist_wdata = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                hist_we    = 1'b1;
                hist_waddr = init_cnt_reg;
            end
            ST_EXEC:
            begin
                hist_we    = (cur_reg.kind == KIND_SAMPLE);
                hist_wdata = cur_reg.value;
            end
            ST_CLEAR:
            begin
                hist_we    = 1'b1;
                hist_waddr = {pos_reg, row_cnt_reg};
            end
            default:
            begin
                hist_we = 1'b0;
            end
        endcase
    end

    bmf_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_q)
    );

    bmf_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_coef_l (
        .clk   (clk),
        .we    (coef_we_l),
        .waddr (coef_addr_w),
        .wdata (cur_reg.value),
        .raddr (coef_addr_r),
        .rdata (coef_l_q)
    );

    bmf_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_coef_r (
        .clk   (clk),
        .we    (coef_we_r),
        .waddr (coef_addr_w),
        .wdata (cur_reg.value),
        .raddr (coef_addr_r),
        .rdata (coef_r_q)
    );

    // mac pipeline: ram read, multiply, accumulate
    always_ff @(posedge clk)
    begin
        prod_l_reg <= hist_q * coef_l_q;
        prod_r_reg <= hist_q * coef_r_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else
        begin
            rd_v_reg  <= issue;
            mul_v_reg <= rd_v_reg;
            if (acc_clear)
            begin
                acc_l_reg <= '0;
                acc_r_reg <= '0;
            end
            else if (mul_v_reg)
            begin
                acc_l_reg <= acc_l_reg + ACC_W'(prod_l_reg);
                acc_r_reg <= acc_r_reg + ACC_W'(prod_r_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cur_reg       <= '0;
            pos_reg       <= '0;
            t_reg         <= '0;
            row_cnt_reg   <= '0;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT:
                begin
                    init_cnt_reg <= init_cnt_reg + 1'b1;
                    if (init_cnt_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q.valid)
                    begin
                        cur_reg   <= q.item;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    t_reg     <= '0;
                    state_reg <= (cur_reg.kind == KIND_COEF) ? ST_IDLE : ST_MAC;
                end
                ST_MAC:
                begin
                    if (t_reg == t_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (!rd_v_reg && !mul_v_reg)
                    begin
                        state_reg <= cur_reg.last ? ST_FINISH : ST_IDLE;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        left_reg      <= sat_l;
                        right_reg     <= sat_r;
                        pos_reg       <= pos_reg + 1'b1;
                        row_cnt_reg   <= '0;
                        state_reg     <= ST_CLEAR;
                    end
                end
                ST_CLEAR:
                begin
                    // zero the new history row so missing harmonics count as zero
                    row_cnt_reg <= row_cnt_reg + 1'b1;
                    if (row_cnt_reg == HARM_W'(MAX_HARMONICS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign status.pop      = (state_reg == ST_IDLE);
    assign status.clearing = (state_reg == ST_INIT);
    assign out_valid       = out_valid_reg;
    assign left_sample     = left_reg;
    assign right_sample    = right_reg;

endmodule

FILE: rtl/binaural_multichannel_fir.sv
// binaural_multichannel_fir: top level, configuration registers, front queue and mac back end
// the single mac per ear takes one queued sample at a time and runs through the taps in use
// before it takes the next; a frame closing sample shows its pair once the mac has drained
// and the output register is free, then the history row clear follows; coefficient writes skip the mac
// after reset a clearing pass zeroes the history ram while input is stalled;
// configuration registers reset to 128 taps, 4 harmonics; depends on bmf_pkg, bmf_front, bmf_back
`timescale 1ns / 1ps

module binaural_multichannel_fir (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [bmf_pkg::HARM_W-1:0]    harmonic,
    input  logic signed [bmf_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [bmf_pkg::TAP_W-1:0]     tap,
    input  logic                          ear,
    input  logic signed [bmf_pkg::SAMPLE_W-1:0] coefficient,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [bmf_pkg::SAMPLE_W-1:0] left_sample,
    output logic signed [bmf_pkg::SAMPLE_W-1:0] right_sample
);
    import bmf_pkg::*;

    logic [TAPS_CFG_W-1:0] taps_reg;
    logic [HARM_CFG_W-1:0] harm_reg;
    queue_t                q;
    back_status_t          status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= TAPS_CFG_W'(128);
            harm_reg <= HARM_CFG_W'(4);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TAPS:      taps_reg <= cfg_data[TAPS_CFG_W-1:0];
                CFG_HARMONICS: harm_reg <= cfg_data[HARM_CFG_W-1:0];
            endcase
        end
    end

    bmf_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .harmonic         (harmonic),
        .tap              (tap),
        .ear              (ear),
        .harmonics_in_use (harm_reg),
        .sample_in        (sample_in),
        .coefficient      (coefficient),
        .status           (status),
        .q                (q)
    );

    bmf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q            (q),
        .status       (status),
        .taps_in_use  (taps_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample)
    );

endmodule
